@@ hw/rtl/urla_pkg.sv @@
// Shared types and constants for the UART RX line assembler.
package urla_pkg;

  // Default number of line buffer entries
  localparam int LineDepthDef = 32;

  // Width of the line_length and read_index fields
  localparam int LenW = 5;
  localparam int IdxW = 5;

  // Sample number of the stop bit
  localparam logic [3:0] StopSample = 4'd10;

  // Line terminator characters
  localparam logic [7:0] CharCr = 8'h0D;
  localparam logic [7:0] CharLf = 8'h0A;

  // Event codes on the input channel
  typedef enum logic [2:0] {
    CMD_START   = 3'd0,
    CMD_SAMPLE  = 3'd1,
    CMD_PAUSE   = 3'd2,
    CMD_RESUME  = 3'd3,
    CMD_READ    = 3'd4,
    CMD_RELEASE = 3'd5
  } urla_cmd_e;

endpackage

@@ hw/rtl/uart_rx_line_assembler_core.sv @@
// UART 8N1 receive event processor with a line buffer.
//
// Input channel: one event per transaction (command_i, rx_level_i,
// read_index_i), taken when in_valid_i is high and in_stall_o is low.
// Output channel: one status transaction per event, taken when
// out_valid_o is high and out_stall_i is low.
// Pipeline: a taken event goes first into the input register, then through
// the state update into the result register, with the buffer read
// registered alongside it.
// Throughput: one event per cycle while out_stall_i is low. The event state,
// the line position and the buffer write all complete in the single update
// stage, so the update itself never stops back-to-back events.
// Stall: while a result waits under out_stall_i, the input register can
// still take one event; in_stall_o rises only when both stages are full.
// Reset (rst_ni low, asynchronous): receiver paused, no character in
// progress, line position zero, buffer unlocked and both stages empty.
// Buffer contents are not cleared; read only entries written since reset.
module uart_rx_line_assembler_core #(
  parameter int LINE_DEPTH = urla_pkg::LineDepthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [2:0]                command_i,
  input  logic                      rx_level_i,
  input  logic [urla_pkg::IdxW-1:0] read_index_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [7:0]                entry_data_o,
  output logic                      line_ready_o,
  output logic                      overflowed_o,
  output logic [urla_pkg::LenW-1:0] line_length_o,
  output logic                      char_done_o,
  output logic                      frame_error_o
);

  localparam int AddrW = $clog2(LINE_DEPTH);
  localparam logic [AddrW-1:0] LastPos = AddrW'(LINE_DEPTH - 1);

  // Pipeline control
  logic advance;
  logic commit;

  // Input register
  logic                      s1_valid_q;
  urla_pkg::urla_cmd_e       s1_cmd_q;
  logic                      s1_level_q;
  logic [urla_pkg::IdxW-1:0] s1_idx_q;

  // Receiver and assembler state
  logic             rx_en_q, rx_en_d;
  logic             rcv_q, rcv_d;
  logic [3:0]       bit_cnt_q, bit_cnt_d;
  logic [7:0]       shift_q, shift_d;
  logic [AddrW-1:0] pos_q, pos_d;
  logic             locked_q, locked_d;
  logic             ovf_q, ovf_d;

  // Per-event results
  logic             done_d, ferr_d;
  logic             wr_en;
  logic [7:0]       wr_data;
  logic             rd_hit;
  logic [3:0]       cnt_inc;

  // Result register
  logic                      out_valid_q;
  logic                      out_locked_q;
  logic                      out_ovf_q;
  logic [urla_pkg::LenW-1:0] out_len_q;
  logic                      out_done_q;
  logic                      out_ferr_q;

  assign advance    = !out_valid_q || !out_stall_i;
  assign commit     = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_cmd_q   <= urla_pkg::urla_cmd_e'(command_i);
      s1_level_q <= rx_level_i;
      s1_idx_q   <= read_index_i;
    end
  end

  // Event update: receiver framing, line assembly and buffer control
  assign cnt_inc = bit_cnt_q + 4'd1;

  always_comb begin
    logic [7:0] ch;
    rx_en_d  = rx_en_q;
    rcv_d    = rcv_q;
    bit_cnt_d = bit_cnt_q;
    shift_d  = shift_q;
    pos_d    = pos_q;
    locked_d = locked_q;
    ovf_d    = ovf_q;
    done_d   = 1'b0;
    ferr_d   = 1'b0;
    wr_en    = 1'b0;
    wr_data  = 8'h00;
    ch       = shift_q;
    unique case (s1_cmd_q)
      urla_pkg::CMD_START: begin
        if (rx_en_q && !s1_level_q) begin
          rx_en_d   = 1'b0;
          rcv_d     = 1'b1;
          shift_d   = 8'h00;
          bit_cnt_d = 4'd0;
        end
      end
      urla_pkg::CMD_SAMPLE: begin
        if (rcv_q) begin
          bit_cnt_d = cnt_inc;
          if (cnt_inc == 4'd1) begin
            // start bit must be low
            if (s1_level_q) begin
              ferr_d    = 1'b1;
              rcv_d     = 1'b0;
              bit_cnt_d = 4'd0;
              rx_en_d   = 1'b1;
            end
          end else if (cnt_inc >= urla_pkg::StopSample) begin
            // stop bit: frame ends either way
            rcv_d     = 1'b0;
            bit_cnt_d = 4'd0;
            rx_en_d   = 1'b1;
            if (!s1_level_q) begin
              ferr_d = 1'b1;
            end else begin
              done_d = 1'b1;
              if (!locked_q) begin
                wr_en = 1'b1;
                if (shift_q == urla_pkg::CharCr) begin
                  ch = 8'h00;
                end else if (shift_q == urla_pkg::CharLf) begin
                  ch = 8'h00;
                  if (pos_q != '0) begin
                    locked_d = 1'b1;
                  end
                end else if (pos_q == LastPos) begin
                  ch       = 8'h00;
                  locked_d = 1'b1;
                  ovf_d    = 1'b1;
                end
                wr_data = ch;
                if (ch != 8'h00 && pos_q != LastPos) begin
                  pos_d = pos_q + AddrW'(1);
                end
              end
            end
          end else begin
            // data bits arrive LSB first
            shift_d = {s1_level_q, shift_q[7:1]};
          end
        end
      end
      urla_pkg::CMD_PAUSE:  rx_en_d = 1'b0;
      urla_pkg::CMD_RESUME: rx_en_d = 1'b1;
      urla_pkg::CMD_READ:   ;
      urla_pkg::CMD_RELEASE: begin
        locked_d = 1'b0;
        ovf_d    = 1'b0;
        pos_d    = '0;
      end
      default: ;
    endcase
  end

  assign rd_hit = (s1_cmd_q == urla_pkg::CMD_READ) && (int'(s1_idx_q) < LINE_DEPTH);

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_en_q   <= 1'b0;
      rcv_q     <= 1'b0;
      bit_cnt_q <= 4'd0;
      shift_q   <= 8'h00;
      pos_q     <= '0;
      locked_q  <= 1'b0;
      ovf_q     <= 1'b0;
    end else if (commit) begin
      rx_en_q   <= rx_en_d;
      rcv_q     <= rcv_d;
      bit_cnt_q <= bit_cnt_d;
      shift_q   <= shift_d;
      pos_q     <= pos_d;
      locked_q  <= locked_d;
      ovf_q     <= ovf_d;
    end
  end

  // Line buffer
  urla_line_buf #(
    .LineDepth(LINE_DEPTH)
  ) u_line_buf (
    .clk_i    (clk_i),
    .wr_en_i  (commit && wr_en),
    .wr_addr_i(pos_q),
    .wr_data_i(wr_data),
    .rd_en_i  (advance),
    .rd_hit_i (s1_valid_q && rd_hit),
    .rd_addr_i(AddrW'(s1_idx_q)),
    .rd_data_o(entry_data_o)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_locked_q <= locked_d;
      out_ovf_q    <= ovf_d;
      out_len_q    <= urla_pkg::LenW'(pos_d);
      out_done_q   <= done_d;
      out_ferr_q   <= ferr_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign line_ready_o  = out_locked_q;
  assign overflowed_o  = out_ovf_q;
  assign line_length_o = out_len_q;
  assign char_done_o   = out_done_q;
  assign frame_error_o = out_ferr_q;

`ifndef SYNTHESIS
  // overflow only ever happens together with a lock
  assert property (@(posedge clk_i) disable iff (!rst_ni) ovf_q |-> locked_q)
    else $error("overflow flag set on an unlocked buffer");

  // bit counter stays below the stop sample and is zero when idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   bit_cnt_q < urla_pkg::StopSample)
    else $error("bit counter ran past the stop sample");

  assert property (@(posedge clk_i) disable iff (!rst_ni) !rcv_q |-> bit_cnt_q == 4'd0)
    else $error("bit counter nonzero while not receiving");

  // a result never reports both a good character and a framing error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_q |-> !(out_done_q && out_ferr_q))
    else $error("char_done and frame_error both set");
`endif

endmodule

@@ hw/rtl/urla_line_buf.sv @@
// Line buffer memory: one write port, one registered read port.
module urla_line_buf #(
  parameter int LineDepth = urla_pkg::LineDepthDef,
  localparam int AddrW = $clog2(LineDepth)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [7:0]       wr_data_i,
  input  logic             rd_en_i,
  input  logic             rd_hit_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [7:0]       rd_data_o
);

  logic [7:0] mem_q [LineDepth];
  logic [7:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port: data held while the result stage is stalled, zero on a miss
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= rd_hit_i ? mem_q[rd_addr_i] : 8'h00;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ tb/sv/uart_rx_line_checker.sv @@
// Transaction monitor, status predictor and scoreboard for the UART RX line assembler.
module uart_rx_line_checker
  import urla_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic [2:0]              command_i,
  input  logic                    rx_level_i,
  input  logic [IdxW-1:0]         read_index_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [7:0]              entry_data_i,
  input  logic                    line_ready_i,
  input  logic                    overflowed_i,
  input  logic [LenW-1:0]         line_length_i,
  input  logic                    char_done_i,
  input  logic                    frame_error_i,
  output int                      fail_count_o,
  output int                      pending_o,
  output logic [LineDepthDef-1:0] written_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxReports = 10;
  localparam logic [LenW-1:0] LastSlot = LenW'(LineDepthDef - 1);

  typedef struct packed {
    logic [7:0]      data;
    logic            ready;
    logic            ovf;
    logic [LenW-1:0] len;
    logic            done;
    logic            ferr;
  } line_status_t;

  // Mirror of the receiver and line buffer
  logic                    rx_en;
  logic                    in_char;
  logic [3:0]              sample_cnt;
  logic [7:0]              shift_reg;
  logic [LenW-1:0]         wr_pos;
  logic                    locked;
  logic                    ovf_flag;
  logic [7:0]              line_bytes [LineDepthDef];
  logic [LineDepthDef-1:0] written;

  line_status_t expected_status_q [$];
  int fails;

  // Character finished, good or bad: receiver idle and start edges enabled
  task automatic end_of_char();
    in_char    = 1'b0;
    sample_cnt = '0;
    rx_en      = 1'b1;
  endtask

  // Apply one event to the mirror and return the status it produces
  task automatic rx_line_step(input logic [2:0] cmd, input logic lvl,
                              input logic [IdxW-1:0] idx, output line_status_t st);
    logic [7:0] ch;
    st = '0;
    case (cmd)
      CMD_START: begin
        if (rx_en && !lvl) begin
          rx_en      = 1'b0;
          in_char    = 1'b1;
          shift_reg  = '0;
          sample_cnt = '0;
        end
      end
      CMD_SAMPLE: begin
        if (in_char) begin
          sample_cnt = sample_cnt + 4'd1;
          if (sample_cnt == 4'd1) begin
            // start bit must read low
            if (lvl) begin
              st.ferr = 1'b1;
              end_of_char();
            end
          end else if (sample_cnt >= StopSample) begin
            if (!lvl) begin
              st.ferr = 1'b1;
            end else begin
              st.done = 1'b1;
              // line assembly; dropped while a line is waiting
              if (!locked) begin
                ch = shift_reg;
                if (ch == CharCr) begin
                  ch = 8'h00;
                end else if (ch == CharLf) begin
                  ch = 8'h00;
                  if (wr_pos != '0) locked = 1'b1;
                end else if (wr_pos == LastSlot) begin
                  ch       = 8'h00;
                  locked   = 1'b1;
                  ovf_flag = 1'b1;
                end
                line_bytes[wr_pos] = ch;
                written[wr_pos]    = 1'b1;
                if (ch != 8'h00 && wr_pos < LastSlot) wr_pos = wr_pos + 1'b1;
              end
            end
            end_of_char();
          end else begin
            // data bits arrive LSB first
            shift_reg = {lvl, shift_reg[7:1]};
          end
        end
      end
      CMD_PAUSE:  rx_en = 1'b0;
      CMD_RESUME: rx_en = 1'b1;
      CMD_READ:   st.data = line_bytes[idx];
      CMD_RELEASE: begin
        locked   = 1'b0;
        ovf_flag = 1'b0;
        wr_pos   = '0;
      end
      default: ;
    endcase
    st.ready = locked;
    st.ovf   = ovf_flag;
    st.len   = wr_pos;
  endtask

  // Compare outgoing transactions first, then log the incoming one
  always @(posedge clk_i or negedge rst_ni) begin
    line_status_t got;
    line_status_t want;
    if (!rst_ni) begin
      rx_en      = 1'b0;
      in_char    = 1'b0;
      sample_cnt = '0;
      shift_reg  = '0;
      wr_pos     = '0;
      locked     = 1'b0;
      ovf_flag   = 1'b0;
      written    = '0;
      fails      = 0;
      expected_status_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      written_o    <= '0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{entry_data_i, line_ready_i, overflowed_i, line_length_i,
                char_done_i, frame_error_i};
        if (expected_status_q.size() == 0) begin
          if (fails < MaxReports)
            $display("%0t: unexpected status: data=%h ready=%b ovf=%b len=%0d done=%b ferr=%b",
                     $realtime, got.data, got.ready, got.ovf, got.len, got.done, got.ferr);
          fails++;
        end else begin
          want = expected_status_q.pop_front();
          if (got !== want) begin
            if (fails < MaxReports) begin
              $display("%0t: mismatch exp data=%h ready=%b ovf=%b len=%0d done=%b ferr=%b",
                       $realtime, want.data, want.ready, want.ovf, want.len, want.done,
                       want.ferr);
              $display("%0t: mismatch got data=%h ready=%b ovf=%b len=%0d done=%b ferr=%b",
                       $realtime, got.data, got.ready, got.ovf, got.len, got.done,
                       got.ferr);
            end
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        rx_line_step(command_i, rx_level_i, read_index_i, want);
        expected_status_q.push_back(want);
      end
      fail_count_o <= fails;
      pending_o    <= expected_status_q.size();
      written_o    <= written;
    end
  end

endmodule

@@ tb/sv/uart_rx_line_assembler_core_test.sv @@
// Stimulus, clocking and verdict for the UART RX line assembler core.
module uart_rx_line_assembler_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import urla_pkg::*;

  localparam int IdlePct    = 13;
  localparam int ItemTarget = 1150;
  localparam int HoldCycles = 80;
  localparam int TailCycles = 10;
  localparam int CycleLimit = 100000;

  // Codes outside the defined event set; the block must leave state alone
  localparam logic [2:0] CmdSpareLo = 3'd6;
  localparam logic [2:0] CmdSpareHi = 3'd7;
  localparam logic [7:0] CharNul    = 8'h00;

  logic            clk_i;
  logic            rst_ni       = 1'b0;
  logic            in_valid_i   = 1'b0;
  logic            in_stall_o;
  logic [2:0]      command_i    = CMD_START;
  logic            rx_level_i   = 1'b1;
  logic [IdxW-1:0] read_index_i = '0;
  logic            out_valid_o;
  logic            out_stall_i  = 1'b0;
  logic [7:0]      entry_data_o;
  logic            line_ready_o;
  logic            overflowed_o;
  logic [LenW-1:0] line_length_o;
  logic            char_done_o;
  logic            frame_error_o;

  int                      fail_count;
  int                      pending;
  logic [LineDepthDef-1:0] written;

  bit gaps_on    = 1'b1;
  bit hold_go    = 1'b0;
  int items_sent = 0;
  int cycle_cnt  = 0;

  uart_rx_line_assembler_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .rx_level_i    (rx_level_i),
    .read_index_i  (read_index_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .entry_data_o  (entry_data_o),
    .line_ready_o  (line_ready_o),
    .overflowed_o  (overflowed_o),
    .line_length_o (line_length_o),
    .char_done_o   (char_done_o),
    .frame_error_o (frame_error_o)
  );

  uart_rx_line_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .command_i     (command_i),
    .rx_level_i    (rx_level_i),
    .read_index_i  (read_index_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .entry_data_i  (entry_data_o),
    .line_ready_i  (line_ready_o),
    .overflowed_i  (overflowed_o),
    .line_length_i (line_length_o),
    .char_done_i   (char_done_o),
    .frame_error_i (frame_error_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .written_o     (written)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_go) begin
        hold_go = 1'b0;
        out_stall_i <= 1'b1;
        for (int n = 0; n < HoldCycles; n++) @(posedge clk_i);
      end else begin
        out_stall_i <= gaps_on && ($urandom_range(99) < IdlePct);
      end
    end
  end

  // One input transaction, with optional idle cycles ahead of it
  task automatic send_event(input logic [2:0] cmd, input logic lvl,
                            input logic [IdxW-1:0] idx, input bit counted);
    if (gaps_on) begin
      while ($urandom_range(99) < IdlePct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    rx_level_i   <= lvl;
    read_index_i <= (cmd == CMD_READ) ? idx : IdxW'($urandom_range(LineDepthDef - 1));
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (counted) items_sent++;
  endtask

  // Pick a buffer entry already written since reset
  function automatic bit pick_entry(output logic [IdxW-1:0] idx);
    int start;
    int slot;
    start = $urandom_range(LineDepthDef - 1);
    pick_entry = 1'b0;
    idx = '0;
    for (int k = 0; k < LineDepthDef; k++) begin
      slot = (start + k) % LineDepthDef;
      if (!pick_entry && written[slot]) begin
        idx = IdxW'(slot);
        pick_entry = 1'b1;
      end
    end
  endfunction

  // One framed character, sometimes broken, paused or restarted
  task automatic send_char(input logic [7:0] c);
    int v;
    int cut;
    v   = $urandom_range(99);
    cut = $urandom_range(8, 1);
    send_event(CMD_START, 1'b0, '0, 1'b1);
    if (v < 4) begin
      // partial character, then resume and a fresh start edge restarts it
      send_event(CMD_SAMPLE, 1'b0, '0, 1'b1);
      for (int k = 0; k < cut; k++) send_event(CMD_SAMPLE, 1'($urandom_range(1)), '0, 1'b1);
      send_event(CMD_RESUME, 1'($urandom_range(1)), '0, 1'b1);
      send_event(CMD_START, 1'b0, '0, 1'b1);
    end
    if (v >= 4 && v < 8) begin
      // start bit reads high
      send_event(CMD_SAMPLE, 1'b1, '0, 1'b1);
    end else begin
      send_event(CMD_SAMPLE, 1'b0, '0, 1'b1);
      for (int k = 0; k < 8; k++) begin
        send_event(CMD_SAMPLE, c[k], '0, 1'b1);
        if (v >= 8 && v < 14 && k == cut - 1)
          send_event(CMD_PAUSE, 1'($urandom_range(1)), '0, 1'b1);
      end
      send_event(CMD_SAMPLE, !(v >= 14 && v < 19), '0, 1'b1);
    end
  endtask

  // A line: characters, terminator, reads, maybe a late character, release
  task automatic send_line(input int len);
    int r;
    logic [7:0] c;
    logic [IdxW-1:0] idx;
    send_event(CMD_RESUME, 1'($urandom_range(1)), '0, 1'b1);
    for (int n = 0; n < len; n++) begin
      r = $urandom_range(99);
      if (len < 20 && r < 4) begin
        c = CharNul;
      end else if (len < 20 && r < 9) begin
        c = CharCr;
      end else begin
        do c = 8'($urandom_range(255));
        while (c == CharCr || c == CharLf || c == CharNul);
      end
      send_char(c);
    end
    r = $urandom_range(99);
    if (r < 45) send_char(CharCr);
    if (r < 80) send_char(CharLf);
    r = $urandom_range(4);
    for (int n = 0; n < r; n++)
      if (pick_entry(idx)) send_event(CMD_READ, 1'($urandom_range(1)), idx, 1'b1);
    if ($urandom_range(99) < 30) send_char(8'($urandom_range(255)));
    if ($urandom_range(99) < 85) send_event(CMD_RELEASE, 1'($urandom_range(1)), '0, 1'b1);
    // a little noise: any command code with random fields
    r = $urandom_range(2);
    for (int n = 0; n < r; n++) begin
      c[2:0] = 3'($urandom_range(7));
      if (c[2:0] != CMD_READ) send_event(c[2:0], 1'($urandom_range(1)), '0, 1'b0);
      else if (pick_entry(idx)) send_event(CMD_READ, 1'($urandom_range(1)), idx, 1'b0);
    end
  endtask

  // Stop offering and wait until every expected status has come back
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Main stimulus and verdict
  initial begin
    bit hold_done;
    bit pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: ignored events, bad start bit, restart, all-ones byte, odd codes
    send_event(CMD_START, 1'b0, '0, 1'b1);
    send_event(CMD_RESUME, 1'b0, '0, 1'b1);
    send_event(CMD_START, 1'b1, '0, 1'b1);
    send_event(CMD_SAMPLE, 1'b0, '0, 1'b1);
    send_event(CMD_PAUSE, 1'b1, '0, 1'b1);
    send_event(CMD_START, 1'b0, '0, 1'b1);
    send_event(CMD_RESUME, 1'b1, '0, 1'b1);
    send_event(CMD_START, 1'b0, '0, 1'b1);
    send_event(CMD_SAMPLE, 1'b1, '0, 1'b1);
    send_event(CMD_START, 1'b0, '0, 1'b1);
    send_event(CMD_SAMPLE, 1'b0, '0, 1'b1);
    send_event(CMD_RESUME, 1'b0, '0, 1'b1);
    send_event(CMD_START, 1'b0, '0, 1'b1);
    send_event(CMD_SAMPLE, 1'b0, '0, 1'b1);
    for (int k = 0; k < 9; k++) send_event(CMD_SAMPLE, 1'b1, '0, 1'b1);
    send_event(CMD_READ, 1'b0, '0, 1'b1);
    send_event(CMD_RELEASE, 1'b1, '0, 1'b1);
    send_event(CmdSpareLo, 1'b0, '0, 1'b1);
    send_event(CmdSpareHi, 1'b1, '0, 1'b1);

    // first random line is one character longer than the buffer, so it may overflow
    send_line(LineDepthDef + 1);
    while (items_sent < ItemTarget) begin
      gaps_on = !(items_sent >= 500 && items_sent < 700);
      if (!hold_done && items_sent >= 300) begin
        hold_go   = 1'b1;
        hold_done = 1'b1;
      end
      if (!pause_done && items_sent >= 850) begin
        wait_for_results();
        pause_done = 1'b1;
      end
      if ($urandom_range(99) < 6) send_line($urandom_range(LineDepthDef + 2, LineDepthDef - 4));
      else send_line($urandom_range(8));
    end

    wait_for_results();
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
